FILE: rtl/core/gpab_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gpab_pkg
// Shared types, constants and the 5x7 font ROM of the glyph pixel blender.
// ----------------------------------------------------------------------------
package gpab_pkg;

  localparam int GLYPH_ROWS = 7;
  localparam int GLYPH_COLS = 5;

  localparam logic [4:0] MAX_SCALE       = 5'd16;
  localparam logic [4:0] ROUND_MIN_SCALE = 5'd3;

  // configuration register indexes
  localparam logic [3:0] CFG_IDX_SCALE = 4'd0;
  localparam logic [3:0] CFG_IDX_INK   = 4'd1;

  localparam logic [4:0]  SCALE_RESET = 5'd2;
  localparam logic [31:0] INK_RESET   = 32'hFFEEEEEE;

  localparam logic [7:0] COV_FULL  = 8'd255;
  localparam logic [7:0] ROUND_ADD = 8'd127;

  // row 0 is the top row, bit 4 of a row is the leftmost column
  typedef logic [0:GLYPH_ROWS-1][GLYPH_COLS-1:0] glyph_t;

  typedef struct packed {
    logic       act;   // corner is rounded and the pixel lies in its radius
    logic [3:0] a;     // radius minus horizontal distance from the corner
    logic [3:0] b;     // radius minus vertical distance from the corner
  } corner_in_t;

  typedef struct packed {
    logic                  cand;   // lit cell and sub-position inside the cell
    corner_in_t [3:0]      crn;
    logic [3:0]            rad;
    logic [31:0]           under;
  } cell_a_t;

  // per-stage load enables of the pipeline
  typedef struct packed {
    logic a;
    logic b;
    logic c;
    logic d;
    logic e;
    logic f;
  } adv_t;

  function automatic glyph_t font_glyph(logic [7:0] code);
    glyph_t g;
    case (code)
      8'h20: g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00};
      8'h2B: g = {5'h00, 5'h04, 5'h04, 5'h1f, 5'h04, 5'h04, 5'h00};
      8'h2D: g = {5'h00, 5'h00, 5'h00, 5'h1f, 5'h00, 5'h00, 5'h00};
      8'h2E: g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h0c, 5'h0c};
      8'h2F: g = {5'h01, 5'h02, 5'h02, 5'h04, 5'h08, 5'h08, 5'h10};
      8'h30: g = {5'h0e, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0e};
      8'h31: g = {5'h04, 5'h0c, 5'h14, 5'h04, 5'h04, 5'h04, 5'h1f};
      8'h32: g = {5'h0e, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1f};
      8'h33: g = {5'h1e, 5'h01, 5'h01, 5'h0e, 5'h01, 5'h01, 5'h1e};
      8'h34: g = {5'h02, 5'h06, 5'h0a, 5'h12, 5'h1f, 5'h02, 5'h02};
      8'h35: g = {5'h1f, 5'h10, 5'h10, 5'h1e, 5'h01, 5'h01, 5'h1e};
      8'h36: g = {5'h0e, 5'h10, 5'h10, 5'h1e, 5'h11, 5'h11, 5'h0e};
      8'h37: g = {5'h1f, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
      8'h38: g = {5'h0e, 5'h11, 5'h11, 5'h0e, 5'h11, 5'h11, 5'h0e};
      8'h39: g = {5'h0e, 5'h11, 5'h11, 5'h0f, 5'h01, 5'h01, 5'h0e};
      8'h41: g = {5'h0e, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11, 5'h11};
      8'h43: g = {5'h0f, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h0f};
      8'h44: g = {5'h1e, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1e};
      8'h45: g = {5'h1f, 5'h10, 5'h10, 5'h1e, 5'h10, 5'h10, 5'h1f};
      8'h47: g = {5'h0f, 5'h10, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0f};
      8'h48: g = {5'h11, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11, 5'h11};
      8'h49: g = {5'h1f, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1f};
      8'h4C: g = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1f};
      8'h4D: g = {5'h11, 5'h1b, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
      8'h61: g = {5'h00, 5'h00, 5'h0e, 5'h01, 5'h0f, 5'h11, 5'h0f};
      8'h64: g = {5'h01, 5'h01, 5'h0f, 5'h11, 5'h11, 5'h11, 5'h0f};
      8'h65: g = {5'h00, 5'h00, 5'h0e, 5'h11, 5'h1f, 5'h10, 5'h0e};
      8'h67: g = {5'h00, 5'h00, 5'h0f, 5'h11, 5'h0f, 5'h01, 5'h0e};
      8'h68: g = {5'h10, 5'h10, 5'h1e, 5'h11, 5'h11, 5'h11, 5'h11};
      8'h69: g = {5'h04, 5'h00, 5'h0c, 5'h04, 5'h04, 5'h04, 5'h0e};
      8'h6D: g = {5'h00, 5'h00, 5'h1a, 5'h15, 5'h15, 5'h15, 5'h15};
      8'h6E: g = {5'h00, 5'h00, 5'h1e, 5'h11, 5'h11, 5'h11, 5'h11};
      8'h6F: g = {5'h00, 5'h00, 5'h0e, 5'h11, 5'h11, 5'h11, 5'h0e};
      8'h70: g = {5'h00, 5'h00, 5'h1e, 5'h11, 5'h1e, 5'h10, 5'h10};
      8'h72: g = {5'h00, 5'h00, 5'h16, 5'h19, 5'h10, 5'h10, 5'h10};
      8'h73: g = {5'h00, 5'h00, 5'h0f, 5'h10, 5'h0e, 5'h01, 5'h1e};
      8'h74: g = {5'h04, 5'h04, 5'h1f, 5'h04, 5'h04, 5'h04, 5'h03};
      8'h75: g = {5'h00, 5'h00, 5'h11, 5'h11, 5'h11, 5'h13, 5'h0d};
      8'h79: g = {5'h00, 5'h00, 5'h11, 5'h11, 5'h0f, 5'h01, 5'h0e};
      8'h4E: g = {5'h11, 5'h19, 5'h19, 5'h15, 5'h13, 5'h13, 5'h11};
      8'h4F: g = {5'h0e, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0e};
      8'h50: g = {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h10, 5'h10, 5'h10};
      8'h52: g = {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h14, 5'h12, 5'h11};
      8'h53: g = {5'h0f, 5'h10, 5'h10, 5'h0e, 5'h01, 5'h01, 5'h1e};
      8'h54: g = {5'h1f, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
      8'h55: g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0e};
      8'h58: g = {5'h11, 5'h11, 5'h0a, 5'h04, 5'h0a, 5'h11, 5'h11};
      8'h59: g = {5'h11, 5'h11, 5'h0a, 5'h04, 5'h04, 5'h04, 5'h04};
      8'h5A: g = {5'h1f, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1f};
      // question mark, also drawn for every unknown code
      default: g = {5'h0e, 5'h11, 5'h01, 5'h02, 5'h04, 5'h00, 5'h04};
    endcase
    return g;
  endfunction

  // cell lookup with everything outside the 5x7 grid unlit
  function automatic logic cell_lit(glyph_t g, logic signed [4:0] r, logic signed [4:0] c);
    logic [2:0] ci;
    ci = 3'd0;
    if (r < 5'sd0 || r > 5'sd6 || c < 5'sd0 || c > 5'sd4) begin
      return 1'b0;
    end
    ci = 3'(3'd4 - c[2:0]);
    return g[r[2:0]][ci];
  endfunction

  function automatic logic [11:0] sq7(logic [6:0] v);
    logic [13:0] p;
    p = 14'(v) * 14'(v);
    return p[11:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/gpab_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gpab channel interfaces
// Valid/ready channels for pixel items, result items and register writes.
// ----------------------------------------------------------------------------
interface gpab_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  char_code;
  logic [2:0]  cell_row;
  logic [2:0]  cell_column;
  logic [3:0]  sub_x;
  logic [3:0]  sub_y;
  logic [31:0] under_pixel;

  modport source (output valid, char_code, cell_row, cell_column, sub_x, sub_y,
                  under_pixel, input ready);
  modport sink   (input valid, char_code, cell_row, cell_column, sub_x, sub_y,
                  under_pixel, output ready);
endinterface

interface gpab_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_out;
  logic        write_enable;
  logic [7:0]  coverage_out;

  modport source (output valid, pixel_out, write_enable, coverage_out, input ready);
  modport sink   (input valid, pixel_out, write_enable, coverage_out, output ready);
endinterface

interface gpab_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/gpab_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gpab_cell
// Stage A: font lookup, 3x3 neighborhood, corner selection and distances.
// ----------------------------------------------------------------------------
module gpab_cell import gpab_pkg::*; (
  input  wire logic        clk,
  input  wire adv_t        ld,
  input  wire logic [4:0]  glyph_scale,
  input  wire logic [7:0]  char_code,
  input  wire logic [2:0]  cell_row,
  input  wire logic [2:0]  cell_column,
  input  wire logic [3:0]  sub_x,
  input  wire logic [3:0]  sub_y,
  input  wire logic [31:0] under_pixel,
  output cell_a_t          cell_a_r
);

  glyph_t            g;
  logic signed [4:0] r, c;
  logic              n, s, w, e, nw, ne, sw, se, here;
  logic [4:0]        scl;
  logic [3:0]        rad;
  logic              rnd, sub_ok;
  logic [3:0]        px_l, px_r, py_t, py_b;
  logic [3:0]        crn_cond;
  logic [3:0][3:0]   cpx, cpy;
  cell_a_t           cell_nxt;

  always_comb begin
    g    = font_glyph(char_code);
    r    = signed'({2'b00, cell_row});
    c    = signed'({2'b00, cell_column});
    here = cell_lit(g, r, c);
    n    = cell_lit(g, r - 5'sd1, c);
    s    = cell_lit(g, r + 5'sd1, c);
    w    = cell_lit(g, r, c - 5'sd1);
    e    = cell_lit(g, r, c + 5'sd1);
    nw   = cell_lit(g, r - 5'sd1, c - 5'sd1);
    ne   = cell_lit(g, r - 5'sd1, c + 5'sd1);
    sw   = cell_lit(g, r + 5'sd1, c - 5'sd1);
    se   = cell_lit(g, r + 5'sd1, c + 5'sd1);

    scl    = (glyph_scale > MAX_SCALE) ? MAX_SCALE : glyph_scale;
    rad    = scl[4:1];
    rnd    = (scl >= ROUND_MIN_SCALE);
    sub_ok = ({1'b0, sub_x} < scl) && ({1'b0, sub_y} < scl);

    // distances from the left/right and top/bottom cell edges
    px_l = sub_x;
    px_r = 4'(scl - 5'd1 - {1'b0, sub_x});
    py_t = sub_y;
    py_b = 4'(scl - 5'd1 - {1'b0, sub_y});

    // corner order: top-left, top-right, bottom-left, bottom-right
    crn_cond = {!s && !e && !se, !s && !w && !sw, !n && !e && !ne, !n && !w && !nw};
    cpx      = {px_r, px_l, px_r, px_l};
    cpy      = {py_b, py_b, py_t, py_t};

    cell_nxt.cand  = here && sub_ok;
    cell_nxt.rad   = rad;
    cell_nxt.under = under_pixel;
    for (int k = 0; k < 4; k++) begin
      cell_nxt.crn[k].act = crn_cond[k] && rnd && (cpx[k] < rad) && (cpy[k] < rad);
      cell_nxt.crn[k].a   = 4'(rad - cpx[k]);
      cell_nxt.crn[k].b   = 4'(rad - cpy[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (ld.a) begin
      cell_a_r <= cell_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/gpab_corner.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gpab_corner
// Stages B and C: 4x4 supersampled circle coverage of one rounded corner.
// ----------------------------------------------------------------------------
module gpab_corner import gpab_pkg::*; (
  input  wire logic       clk,
  input  wire adv_t       ld,
  input  wire corner_in_t crn_a,
  input  wire logic [3:0] rad_a,
  output logic [7:0]      cov_c_r
);

  logic             act_b_r;
  logic [3:0][11:0] dxsq_b_r, dysq_b_r;
  logic [12:0]      rsq_b_r;

  logic [3:0][11:0] dxsq, dysq;
  logic [12:0]      rsq;
  logic [13:0]      rprod;
  logic [6:0]       r8;
  logic [15:0]      hits;
  logic [4:0]       cnt;
  logic [12:0]      scaled;
  logic [7:0]       cov_nxt;

  // sample offsets 1, 3, 5, 7 in eighths of a pixel
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      dxsq[i] = sq7(7'({crn_a.a, 3'b000}) - 7'(2 * i + 1));
      dysq[i] = sq7(7'({crn_a.b, 3'b000}) - 7'(2 * i + 1));
    end
    r8    = {rad_a, 3'b000};
    rprod = 14'(r8) * 14'(r8);
    rsq   = rprod[12:0];
  end

  always_ff @(posedge clk) begin
    if (ld.b) begin
      act_b_r  <= crn_a.act;
      dxsq_b_r <= dxsq;
      dysq_b_r <= dysq;
      rsq_b_r  <= rsq;
    end
  end

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      for (int i = 0; i < 4; i++) begin
        hits[j * 4 + i] = (13'(dxsq_b_r[i]) + 13'(dysq_b_r[j])) <= rsq_b_r;
      end
    end
    cnt     = 5'($countones(hits));
    // (cnt * 255 + 8) / 16
    scaled  = (13'(cnt) << 8) - 13'(cnt) + 13'd8;
    cov_nxt = act_b_r ? scaled[11:4] : COV_FULL;
  end

  always_ff @(posedge clk) begin
    if (ld.c) begin
      cov_c_r <= cov_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/gpab_blend.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gpab_blend
// Stages D to F: corner minimum, per-channel ink mix and rounded /255.
// ----------------------------------------------------------------------------
module gpab_blend import gpab_pkg::*; (
  input  wire logic            clk,
  input  wire adv_t            ld,
  input  wire logic [31:0]     ink_color,
  input  wire logic            cand_c,
  input  wire logic [31:0]     under_c,
  input  wire logic [3:0][7:0] cov_c,
  output logic [31:0]          pixel_f_r,
  output logic                 we_f_r,
  output logic [7:0]           cov_f_r
);

  // stage D
  logic [7:0]  m01, m23, cmin;
  logic        we_d_r;
  logic [7:0]  cov_d_r, inv_d_r;
  logic [31:0] under_d_r;

  // stage E
  logic [3:0][15:0] sum_e_r, sum_nxt;
  logic             we_e_r;
  logic [7:0]       cov_e_r;
  logic [31:0]      under_e_r;

  // stage F
  logic [3:0][16:0] q17;
  logic [31:0]      mixed;

  always_comb begin
    m01  = (cov_c[0] < cov_c[1]) ? cov_c[0] : cov_c[1];
    m23  = (cov_c[2] < cov_c[3]) ? cov_c[2] : cov_c[3];
    cmin = (m01 < m23) ? m01 : m23;
  end

  always_ff @(posedge clk) begin
    if (ld.d) begin
      we_d_r    <= cand_c && (cmin != 8'd0);
      cov_d_r   <= cmin;
      inv_d_r   <= COV_FULL - cmin;
      under_d_r <= under_c;
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sum_nxt[k] = 16'(16'(under_d_r[8*k +: 8]) * 16'(inv_d_r))
                 + 16'(16'(ink_color[8*k +: 8]) * 16'(cov_d_r))
                 + 16'(ROUND_ADD);
    end
  end

  always_ff @(posedge clk) begin
    if (ld.e) begin
      sum_e_r   <= sum_nxt;
      we_e_r    <= we_d_r;
      cov_e_r   <= cov_d_r;
      under_e_r <= under_d_r;
    end
  end

  // x / 255 = (x + 1 + x / 256) / 256 over the range of these sums
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      q17[k]          = 17'(sum_e_r[k]) + 17'd1 + 17'(sum_e_r[k][15:8]);
      mixed[8*k +: 8] = q17[k][15:8];
    end
  end

  always_ff @(posedge clk) begin
    if (ld.f) begin
      we_f_r    <= we_e_r;
      cov_f_r   <= we_e_r ? cov_e_r : 8'd0;
      pixel_f_r <= we_e_r ? mixed : under_e_r;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/glyph_pixel_antialias_blend.sv
`default_nettype none
// ----------------------------------------------------------------------------
// glyph_pixel_antialias_blend
// Antialiased 5x7 font pixel blender with rounded glyph corners.
// ----------------------------------------------------------------------------
//  channel  | dir | payload
//  in_ch    | in  | char_code, cell_row, cell_column, sub_x, sub_y, under_pixel
//  out_ch   | out | pixel_out, write_enable, coverage_out
//  cfg_ch   | in  | index (0 glyph_scale, 1 ink_color), data
//
//  One item per clock while the output is ready; one register stage each for
//  cell lookup, corner distance squares, sample count, corner minimum,
//  channel products and the /255 rounding that feeds the output register.
//  Each stage loads when it is empty or the next one moves, so bubbles close
//  up and a stalled output still lets upstream stages fill.
//  Synchronous active-low reset clears valid bits and loads register defaults.
// ----------------------------------------------------------------------------
module glyph_pixel_antialias_blend import gpab_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  gpab_in_if.sink     in_ch,
  gpab_out_if.source  out_ch,
  gpab_cfg_if.sink    cfg_ch
);

  localparam int NSTG = 6;

  logic [4:0]      glyph_scale_r;
  logic [31:0]     ink_color_r;
  logic [NSTG-1:0] vld_r, vin, rdy;
  adv_t            ld;

  cell_a_t         cell_a_r;
  logic            cand_b_r, cand_c_r;
  logic [31:0]     under_b_r, under_c_r;
  logic [3:0][7:0] cov_c;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glyph_scale_r <= SCALE_RESET;
      ink_color_r   <= INK_RESET;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == CFG_IDX_SCALE) begin
        glyph_scale_r <= cfg_ch.data[4:0];
      end else if (cfg_ch.index == CFG_IDX_INK) begin
        ink_color_r <= cfg_ch.data;
      end
    end
  end

  // stage k takes a new item when empty or when stage k+1 takes its item
  always_comb begin
    vin = {vld_r[NSTG-2:0], in_ch.valid};
    rdy[NSTG-1] = !vld_r[NSTG-1] || out_ch.ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    ld.a = rdy[0] && vin[0];
    ld.b = rdy[1] && vin[1];
    ld.c = rdy[2] && vin[2];
    ld.d = rdy[3] && vin[3];
    ld.e = rdy[4] && vin[4];
    ld.f = rdy[5] && vin[5];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vin[k];
        end
      end
    end
  end

  assign in_ch.ready  = rdy[0];
  assign out_ch.valid = vld_r[NSTG-1];

  gpab_cell u_cell (
    .clk         (clk),
    .ld          (ld),
    .glyph_scale (glyph_scale_r),
    .char_code   (in_ch.char_code),
    .cell_row    (in_ch.cell_row),
    .cell_column (in_ch.cell_column),
    .sub_x       (in_ch.sub_x),
    .sub_y       (in_ch.sub_y),
    .under_pixel (in_ch.under_pixel),
    .cell_a_r    (cell_a_r)
  );

  for (genvar k = 0; k < 4; k++) begin : g_crn
    gpab_corner u_corner (
      .clk     (clk),
      .ld      (ld),
      .crn_a   (cell_a_r.crn[k]),
      .rad_a   (cell_a_r.rad),
      .cov_c_r (cov_c[k])
    );
  end

  // carry the pass-through fields alongside the corner stages
  always_ff @(posedge clk) begin
    if (ld.b) begin
      cand_b_r  <= cell_a_r.cand;
      under_b_r <= cell_a_r.under;
    end
    if (ld.c) begin
      cand_c_r  <= cand_b_r;
      under_c_r <= under_b_r;
    end
  end

  gpab_blend u_blend (
    .clk       (clk),
    .ld        (ld),
    .ink_color (ink_color_r),
    .cand_c    (cand_c_r),
    .under_c   (under_c_r),
    .cov_c     (cov_c),
    .pixel_f_r (out_ch.pixel_out),
    .we_f_r    (out_ch.write_enable),
    .cov_f_r   (out_ch.coverage_out)
  );

`ifndef SYNTHESIS
  a_we_cov: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.write_enable |-> out_ch.coverage_out != 8'd0)
    else $error("write item with zero coverage");

  a_nowe_cov: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.write_enable |-> out_ch.coverage_out == 8'd0)
    else $error("skipped item carries coverage");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> ($countones(vld_r) == NSTG) && !out_ch.ready)
    else $error("input stalled while pipeline has room");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NSTG-2] && out_ch.ready |=> out_ch.valid)
    else $error("item lost between last stages");
`endif

endmodule

`default_nettype wire
